FILE: design/gnl_pkg.sv
`timescale 1ns / 1ps

package gnl_pkg;

    // fixed field widths of the stream words
    localparam int DIM_W       = 16;
    localparam int SLOT_IN_W   = 8;
    localparam int BATCH_W     = 16;
    localparam int BANK_W      = 2;
    localparam int BANK_COUNT  = 4;
    localparam int COUNT_W     = 9;
    localparam int CFG_INDEX_W = 4;

    // stream word widths
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    // slave tuser bit positions
    localparam int TUSER_KIND   = 0;
    localparam int TUSER_SINGLE = 1;
    localparam int TUSER_TRANS  = 2;

    // item operation after classification
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // one queued item between front and back
    typedef struct packed {
        op_t                  op;
        logic [BANK_W-1:0]    bank;
        logic [SLOT_IN_W-1:0] slot;
        logic [DIM_W-1:0]     dim_m;
        logic [DIM_W-1:0]     dim_n;
        logic [DIM_W-1:0]     dim_k;
        logic [BATCH_W-1:0]   batch;
        logic                 flag;
    } item_t;

endpackage

FILE: design/gnl_front.sv
`timescale 1ns / 1ps

module gnl_front #(
    parameter int TABLE_DEPTH = 256,
    parameter int DIM_BITS    = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gnl_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [gnl_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          q_valid,
    input  logic                          q_ready,
    output gnl_pkg::item_t                q_item
);

    localparam logic [gnl_pkg::DIM_W-1:0] DIM_MASK = (DIM_BITS >= gnl_pkg::DIM_W) ?
        {gnl_pkg::DIM_W{1'b1}} : gnl_pkg::DIM_W'((64'd1 << DIM_BITS) - 64'd1);

    gnl_pkg::item_t item_in;
    logic           keep;
    logic           push;
    logic           pop;

    gnl_pkg::item_t q_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     cnt_reg;

    // classify the incoming word and mask dimensions
    always_comb
    begin
        item_in.op    = s_tuser[gnl_pkg::TUSER_KIND] ? gnl_pkg::OP_QUERY : gnl_pkg::OP_LOAD;
        item_in.bank  = {s_tuser[gnl_pkg::TUSER_SINGLE], s_tuser[gnl_pkg::TUSER_TRANS]};
        item_in.slot  = s_tdata[7:0];
        item_in.dim_m = s_tdata[23:8] & DIM_MASK;
        item_in.dim_n = s_tdata[39:24] & DIM_MASK;
        item_in.dim_k = s_tdata[55:40] & DIM_MASK;
        item_in.batch = s_tdata[71:56];
        item_in.flag  = s_tdata[72];
        // loads beyond the bank depth are dropped here
        keep = (item_in.op == gnl_pkg::OP_QUERY) || (32'(item_in.slot) < 32'(TABLE_DEPTH));
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready && keep;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = q_reg[rd_ptr_reg];

    // queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= item_in;
    end

endmodule

FILE: design/gnl_back.sv
`timescale 1ns / 1ps

module gnl_back #(
    parameter int TABLE_DEPTH = 256,
    parameter int DIM_BITS    = 16
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                q_valid,
    output logic                                                q_ready,
    input  gnl_pkg::item_t                                      q_item,
    input  logic [gnl_pkg::BANK_COUNT-1:0][gnl_pkg::COUNT_W-1:0] entry_counts,
    output logic                                                out_valid,
    input  logic                                                out_ready,
    output logic [gnl_pkg::BATCH_W-1:0]                         out_n_batch,
    output logic                                                out_use_flag,
    output logic                                                out_found
);

    localparam int SHAPE_W = (DIM_BITS < gnl_pkg::DIM_W) ? DIM_BITS : gnl_pkg::DIM_W;
    localparam int SQ_W    = 2 * SHAPE_W;
    localparam int DIST_W  = SQ_W + 2;
    localparam int SLOT_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ADDR_W  = gnl_pkg::BANK_W + SLOT_W;
    localparam int DEPTH   = gnl_pkg::BANK_COUNT * (1 << SLOT_W);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W   = (CNT_W > gnl_pkg::COUNT_W) ? CNT_W : gnl_pkg::COUNT_W;
    localparam int REC_W   = 3 * SHAPE_W + gnl_pkg::BATCH_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg;

    // record memory: {flag, batch, k, n, m}
    logic [REC_W-1:0] rec_mem [DEPTH];
    logic [REC_W-1:0] rd_data_reg;

    // query context
    logic [gnl_pkg::BANK_W-1:0]  bank_reg;
    logic [SHAPE_W-1:0]          qm_reg;
    logic [SHAPE_W-1:0]          qn_reg;
    logic [SHAPE_W-1:0]          qk_reg;
    logic [gnl_pkg::BATCH_W-1:0] qn_full_reg;
    logic [CNT_W-1:0]            scan_cnt_reg;
    logic [CNT_W-1:0]            idx_reg;

    // scan pipeline
    logic                        v1_reg;
    logic                        v2_reg;
    logic                        v3_reg;
    logic [SHAPE_W-1:0]          diff_m_reg;
    logic [SHAPE_W-1:0]          diff_n_reg;
    logic [SHAPE_W-1:0]          diff_k_reg;
    logic [SQ_W-1:0]             sq_m_reg;
    logic [SQ_W-1:0]             sq_n_reg;
    logic [SQ_W-1:0]             sq_k_reg;
    logic [SHAPE_W-1:0]          n2_reg;
    logic [SHAPE_W-1:0]          n3_reg;
    logic [gnl_pkg::BATCH_W-1:0] batch2_reg;
    logic [gnl_pkg::BATCH_W-1:0] batch3_reg;
    logic                        flag2_reg;
    logic                        flag3_reg;

    // best record so far
    logic                        have_reg;
    logic                        zero_hit_reg;
    logic [DIST_W-1:0]           best_dist_reg;
    logic [SHAPE_W-1:0]          best_n_reg;
    logic [gnl_pkg::BATCH_W-1:0] best_batch_reg;
    logic                        best_flag_reg;

    // result register
    logic                        out_valid_reg;
    logic [gnl_pkg::BATCH_W-1:0] n_batch_reg;
    logic                        use_flag_reg;
    logic                        found_reg;

    logic [CMP_W-1:0]            cnt_wide;
    logic [CNT_W-1:0]            cnt_clamped;
    logic                        issue;
    logic [ADDR_W-1:0]           rd_addr;
    logic [ADDR_W-1:0]           wr_addr;
    logic                        wr_en;
    logic [REC_W-1:0]            wr_data;
    logic [SHAPE_W-1:0]          rd_m;
    logic [SHAPE_W-1:0]          rd_n;
    logic [SHAPE_W-1:0]          rd_k;
    logic [DIST_W-1:0]           sq_dist;
    logic                        better;
    logic                        out_free;
    logic [gnl_pkg::BATCH_W-1:0] n_batch_next;

    assign q_ready = (state_reg == ST_IDLE);

    // entry count of the selected bank, clamped to the bank depth
    always_comb
    begin
        cnt_wide = CMP_W'(entry_counts[q_item.bank]);
        if (cnt_wide > CMP_W'(TABLE_DEPTH))
            cnt_clamped = CNT_W'(TABLE_DEPTH);
        else
            cnt_clamped = CNT_W'(cnt_wide);
    end

    // record write on a load item
    assign wr_en   = q_valid && q_ready && (q_item.op == gnl_pkg::OP_LOAD);
    assign wr_addr = {q_item.bank, SLOT_W'(q_item.slot)};
    assign wr_data = {q_item.flag, q_item.batch, SHAPE_W'(q_item.dim_k),
                      SHAPE_W'(q_item.dim_n), SHAPE_W'(q_item.dim_m)};

    // one record read per cycle while scanning
    assign issue   = (state_reg == ST_SCAN) && (idx_reg != scan_cnt_reg) && !zero_hit_reg;
    assign rd_addr = {bank_reg, SLOT_W'(idx_reg)};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            rec_mem[wr_addr] <= wr_data;
        if (issue)
            rd_data_reg <= rec_mem[rd_addr];
    end

    assign rd_m = rd_data_reg[SHAPE_W-1:0];
    assign rd_n = rd_data_reg[2*SHAPE_W-1:SHAPE_W];
    assign rd_k = rd_data_reg[3*SHAPE_W-1:2*SHAPE_W];

    // distance stages: absolute difference, square, sum
    always_ff @(posedge clk)
    begin
        diff_m_reg <= (rd_m >= qm_reg) ? (rd_m - qm_reg) : (qm_reg - rd_m);
        diff_n_reg <= (rd_n >= qn_reg) ? (rd_n - qn_reg) : (qn_reg - rd_n);
        diff_k_reg <= (rd_k >= qk_reg) ? (rd_k - qk_reg) : (qk_reg - rd_k);
        n2_reg     <= rd_n;
        batch2_reg <= rd_data_reg[3*SHAPE_W+gnl_pkg::BATCH_W-1:3*SHAPE_W];
        flag2_reg  <= rd_data_reg[REC_W-1];

        sq_m_reg   <= SQ_W'(diff_m_reg) * SQ_W'(diff_m_reg);
        sq_n_reg   <= SQ_W'(diff_n_reg) * SQ_W'(diff_n_reg);
        sq_k_reg   <= SQ_W'(diff_k_reg) * SQ_W'(diff_k_reg);
        n3_reg     <= n2_reg;
        batch3_reg <= batch2_reg;
        flag3_reg  <= flag2_reg;
    end

    assign sq_dist = DIST_W'(sq_m_reg) + DIST_W'(sq_n_reg) + DIST_W'(sq_k_reg);
    assign better  = v3_reg && (!have_reg || (sq_dist < best_dist_reg));

    // best record payload
    always_ff @(posedge clk)
    begin
        if (better)
        begin
            best_dist_reg  <= sq_dist;
            best_n_reg     <= n3_reg;
            best_batch_reg <= batch3_reg;
            best_flag_reg  <= flag3_reg;
        end
    end

    // query context capture
    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready && (q_item.op == gnl_pkg::OP_QUERY))
        begin
            bank_reg     <= q_item.bank;
            qm_reg       <= SHAPE_W'(q_item.dim_m);
            qn_reg       <= SHAPE_W'(q_item.dim_n);
            qk_reg       <= SHAPE_W'(q_item.dim_k);
            qn_full_reg  <= q_item.dim_n;
            scan_cnt_reg <= cnt_clamped;
        end
    end

    // chosen batch size: query n when no record was found or the record n equals its batch
    always_comb
    begin
        if (!have_reg || (gnl_pkg::BATCH_W'(best_n_reg) == best_batch_reg))
            n_batch_next = qn_full_reg;
        else
            n_batch_next = best_batch_reg;
    end

    assign out_free = !out_valid_reg || out_ready;

    // sequencer with scan control and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            have_reg      <= 1'b0;
            zero_hit_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            n_batch_reg   <= '0;
            use_flag_reg  <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            // result word is loaded in done, dropped once taken
            if ((state_reg == ST_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid && (q_item.op == gnl_pkg::OP_QUERY))
                    begin
                        idx_reg      <= '0;
                        have_reg     <= 1'b0;
                        zero_hit_reg <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (issue)
                        idx_reg <= idx_reg + CNT_W'(1);
                    if (better)
                        have_reg <= 1'b1;
                    // an exact match ends the scan
                    if (v3_reg && (sq_dist == '0))
                        zero_hit_reg <= 1'b1;
                    if (!issue && !v1_reg && !v2_reg && !v3_reg)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        n_batch_reg  <= n_batch_next;
                        use_flag_reg <= have_reg && best_flag_reg;
                        found_reg    <= have_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_n_batch  = n_batch_reg;
    assign out_use_flag = use_flag_reg;
    assign out_found    = found_reg;

    // scan pipeline is empty outside a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SCAN) |-> (!v1_reg && !v2_reg && !v3_reg))
        else $error("scan pipeline busy outside a scan");

    // read index never passes the clamped entry count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg <= scan_cnt_reg))
        else $error("scan index beyond entry count");

    // an exact match implies a chosen record
    assert property (@(posedge clk) disable iff (!rst_n)
        zero_hit_reg |-> have_reg)
        else $error("exact match without a chosen record");

    // an empty result never carries the use flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> !use_flag_reg)
        else $error("use flag set on an empty bank result");

endmodule

FILE: design/gemm_tuning_nearest_lookup_unit.sv
`timescale 1ns / 1ps
// a query holds the back end from its acceptance until its result is registered, scanning
//   the clamped entry count of its bank, fewer records when an exact match ends the scan;
//   a load is written while the back end is idle, and no new item is taken during a query;
//   while scanning, one record per cycle through the single read port of the memory
// reset: clears entry counts, queue and result register; record memory is not cleared
module gemm_tuning_nearest_lookup_unit #(
    parameter int TABLE_DEPTH = 256,
    parameter int DIM_BITS    = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config write port
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gnl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gnl_pkg::COUNT_W-1:0]     cfg_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_index[7:0], dim_m[23:8], dim_n[39:24], dim_k[55:40],
    // rec_n_batch[71:56], rec_use_flag[72], zero pad[79:73]
    input  logic [gnl_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind[0], single_precision[1], transposed[2]
    input  logic [gnl_pkg::S_TUSER_W-1:0]   s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // n_batch[15:0], use_flag[16], zero pad[23:17]
    output logic [gnl_pkg::M_TDATA_W-1:0]   m_tdata,
    // found[0]
    output logic [gnl_pkg::M_TUSER_W-1:0]   m_tuser
);

    logic [gnl_pkg::BANK_COUNT-1:0][gnl_pkg::COUNT_W-1:0] count_reg;

    logic                        q_valid;
    logic                        q_ready;
    gnl_pkg::item_t              q_item;
    logic [gnl_pkg::BATCH_W-1:0] n_batch;
    logic                        use_flag;
    logic                        found;

    // entry count registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cfg_valid && (32'(cfg_index) < gnl_pkg::BANK_COUNT))
            count_reg[cfg_index[gnl_pkg::BANK_W-1:0]] <= cfg_data;
    end

    gnl_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .DIM_BITS    (DIM_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    gnl_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .DIM_BITS    (DIM_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .entry_counts (count_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_n_batch  (n_batch),
        .out_use_flag (use_flag),
        .out_found    (found)
    );

    // pack the result word
    assign m_tdata = {7'd0, use_flag, n_batch};
    assign m_tuser = found;

endmodule

FILE: tb/gemm_tuning_nearest_lookup_unit_test.sv
`timescale 1ns / 1ps

module gemm_tuning_nearest_lookup_unit_test;

    // package constants used here
    localparam int DIM_W       = gnl_pkg::DIM_W;
    localparam int SLOT_IN_W   = gnl_pkg::SLOT_IN_W;
    localparam int BATCH_W     = gnl_pkg::BATCH_W;
    localparam int BANK_W      = gnl_pkg::BANK_W;
    localparam int BANK_COUNT  = gnl_pkg::BANK_COUNT;
    localparam int COUNT_W     = gnl_pkg::COUNT_W;
    localparam int CFG_INDEX_W = gnl_pkg::CFG_INDEX_W;
    localparam int S_TDATA_W   = gnl_pkg::S_TDATA_W;
    localparam int S_TUSER_W   = gnl_pkg::S_TUSER_W;
    localparam int M_TDATA_W   = gnl_pkg::M_TDATA_W;
    localparam int M_TUSER_W   = gnl_pkg::M_TUSER_W;

    localparam int TABLE_DEPTH    = 256;
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = TABLE_DEPTH + 44;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HEAVY_IDLE_PCT = 84;
    localparam int LIGHT_IDLE_PCT = 14;
    localparam int PHASE_COUNT    = 12;
    localparam int PHASE_WORDS    = 125;
    localparam int FULL_SCAN_PHASE = 5;
    localparam int OVERSIZE_PHASE  = 10;
    localparam int COUNT_MAX      = (1 << COUNT_W) - 1;
    localparam int S_PAD_W        = S_TDATA_W - SLOT_IN_W - 3 * DIM_W - BATCH_W - 1;

    // register indexes of the config port
    localparam logic [CFG_INDEX_W-1:0] REG_ENTRIES_DOUBLE_NORMAL     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ENTRIES_DOUBLE_TRANSPOSED = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ENTRIES_SINGLE_NORMAL     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ENTRIES_SINGLE_TRANSPOSED = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED              = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_INDEX_MAX                 = 4'd15;

    // bank numbers: precision in the high bit, A layout in the low bit
    localparam logic [BANK_W-1:0] BANK_DOUBLE_NORMAL     = 2'd0;
    localparam logic [BANK_W-1:0] BANK_DOUBLE_TRANSPOSED = 2'd1;
    localparam logic [BANK_W-1:0] BANK_SINGLE_NORMAL     = 2'd2;
    localparam logic [BANK_W-1:0] BANK_SINGLE_TRANSPOSED = 2'd3;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef enum logic {
        ROW_WORD,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        logic [DIM_W-1:0] m;
        logic [DIM_W-1:0] n;
        logic [DIM_W-1:0] k;
    } rec_shape_t;

    typedef struct packed {
        logic [BATCH_W-1:0] n_batch;
        logic               use_flag;
        logic               found;
    } lookup_result_t;

    typedef struct packed {
        row_kind_t            what;
        gnl_pkg::op_t         op;
        logic [BANK_W-1:0]    bank;
        logic [SLOT_IN_W-1:0] slot;
        rec_shape_t           dims;
        logic [BATCH_W-1:0]   batch;
        logic                 flag;
        logic                 typed;
        lookup_result_t       typed_result;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [COUNT_W-1:0]   reg_value;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [COUNT_W-1:0]     cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [S_TUSER_W-1:0]   s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;

    // mirror of the record banks and entry counts
    rec_shape_t         shape_store [BANK_COUNT][TABLE_DEPTH];
    logic [BATCH_W-1:0] batch_store [BANK_COUNT][TABLE_DEPTH];
    logic               flag_store  [BANK_COUNT][TABLE_DEPTH];
    bit                 written     [BANK_COUNT][TABLE_DEPTH];
    logic [COUNT_W-1:0] entry_limit [BANK_COUNT];

    lookup_result_t pending_results[$];
    stim_row_t      directed_rows[$];

    idle_mode_t idle_mode = IDLE_NONE;
    int errors = 0;
    int words_sent = 0;
    int loads_sent = 0;
    int queries_sent = 0;
    int results_checked = 0;
    int quiet_cycles = 0;

    gemm_tuning_nearest_lookup_unit #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .DIM_BITS   (DIM_W)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // row builders
    function automatic stim_row_t load_row(logic [BANK_W-1:0] bank, logic [SLOT_IN_W-1:0] slot,
                                           logic [DIM_W-1:0] m, logic [DIM_W-1:0] n,
                                           logic [DIM_W-1:0] k, logic [BATCH_W-1:0] batch,
                                           logic flag);
        stim_row_t r;
        r = '0;
        r.what = ROW_WORD;
        r.op = gnl_pkg::OP_LOAD;
        r.bank = bank;
        r.slot = slot;
        r.dims = '{m, n, k};
        r.batch = batch;
        r.flag = flag;
        return r;
    endfunction

    function automatic stim_row_t query_row(logic [BANK_W-1:0] bank, logic [DIM_W-1:0] m,
                                            logic [DIM_W-1:0] n, logic [DIM_W-1:0] k);
        stim_row_t r;
        r = '0;
        r.what = ROW_WORD;
        r.op = gnl_pkg::OP_QUERY;
        r.bank = bank;
        r.dims = '{m, n, k};
        return r;
    endfunction

    // query whose answer is written down directly
    function automatic stim_row_t known_query_row(logic [BANK_W-1:0] bank, logic [DIM_W-1:0] m,
                                                  logic [DIM_W-1:0] n, logic [DIM_W-1:0] k,
                                                  logic [BATCH_W-1:0] n_batch, logic use_flag,
                                                  logic found);
        stim_row_t r;
        r = query_row(bank, m, n, k);
        r.typed = 1'b1;
        r.typed_result = '{n_batch, use_flag, found};
        return r;
    endfunction

    function automatic stim_row_t reg_row(logic [CFG_INDEX_W-1:0] index,
                                          logic [COUNT_W-1:0] value);
        stim_row_t r;
        r = '0;
        r.what = ROW_REG;
        r.reg_index = index;
        r.reg_value = value;
        return r;
    endfunction

    // predictor
    function automatic int clamped_limit(logic [BANK_W-1:0] bank);
        return (entry_limit[bank] > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_limit[bank]);
    endfunction

    function automatic int written_prefix(logic [BANK_W-1:0] bank);
        int p;
        p = 0;
        while (p < TABLE_DEPTH && written[bank][p])
            p++;
        return p;
    endfunction

    function automatic logic [63:0] shape_distance(rec_shape_t a, rec_shape_t b);
        logic [63:0] dm;
        logic [63:0] dn;
        logic [63:0] dk;
        dm = (a.m >= b.m) ? 64'(a.m - b.m) : 64'(b.m - a.m);
        dn = (a.n >= b.n) ? 64'(a.n - b.n) : 64'(b.n - a.n);
        dk = (a.k >= b.k) ? 64'(a.k - b.k) : 64'(b.k - a.k);
        return dm * dm + dn * dn + dk * dk;
    endfunction

    // first record at the smallest distance, scan ends on an exact shape
    function automatic lookup_result_t nearest_choice(logic [BANK_W-1:0] bank, rec_shape_t q);
        int lim;
        int i;
        int best;
        bit have;
        bit exact;
        logic [63:0] d;
        logic [63:0] best_d;
        lookup_result_t r;
        lim = clamped_limit(bank);
        have = 1'b0;
        exact = 1'b0;
        best = 0;
        best_d = '0;
        for (i = 0; i < lim && !exact; i++)
        begin
            d = shape_distance(shape_store[bank][i], q);
            if (!have || d < best_d)
            begin
                have = 1'b1;
                best_d = d;
                best = i;
            end
            exact = (d == 0);
        end
        if (have)
        begin
            r.n_batch = (shape_store[bank][best].n == batch_store[bank][best]) ?
                        q.n : batch_store[bank][best];
            r.use_flag = flag_store[bank][best];
            r.found = 1'b1;
        end
        else
            r = '{q.n, 1'b0, 1'b0};
        return r;
    endfunction

    // stimulus generation
    function automatic logic [DIM_W-1:0] random_dim();
        case ($urandom_range(0, 3))
            0: return DIM_W'($urandom_range(0, 65535));
            1: return DIM_W'($urandom_range(0, 15));
            2: return 16'hFFFF - DIM_W'($urandom_range(0, 15));
            default:
                case ($urandom_range(0, 5))
                    0: return 16'h0000;
                    1: return 16'h0001;
                    2: return 16'h0040;
                    3: return 16'h0400;
                    4: return 16'h8000;
                    default: return 16'hFFFF;
                endcase
        endcase
    endfunction

    function automatic stim_row_t random_load(bit fill);
        logic [BANK_W-1:0] bank;
        int p;
        int slot;
        logic [DIM_W-1:0] n;
        logic [BATCH_W-1:0] batch;
        bank = fill ? BANK_SINGLE_TRANSPOSED : BANK_W'($urandom_range(0, BANK_COUNT - 1));
        p = written_prefix(bank);
        if ((fill || $urandom_range(0, 1)) && p < TABLE_DEPTH)
            slot = p;
        else
            slot = $urandom_range(0, TABLE_DEPTH - 1);
        n = random_dim();
        case ($urandom_range(0, 4))
            0, 1: batch = n;
            2: batch = BATCH_W'($urandom_range(0, 15));
            default: batch = BATCH_W'($urandom_range(0, 65535));
        endcase
        return load_row(bank, SLOT_IN_W'(slot), random_dim(), n, random_dim(), batch,
                        1'($urandom_range(0, 1)));
    endfunction

    function automatic stim_row_t random_query();
        logic [BANK_W-1:0] bank;
        int lim;
        int pick;
        rec_shape_t q;
        bank = BANK_W'($urandom_range(0, BANK_COUNT - 1));
        lim = clamped_limit(bank);
        pick = $urandom_range(0, 9);
        if (lim > 0 && pick < 5)
        begin
            // a stored shape, exact or slightly off
            q = shape_store[bank][$urandom_range(0, lim - 1)];
            if (pick >= 3)
                q.k = q.k ^ DIM_W'($urandom_range(1, 3));
        end
        else
            q = '{random_dim(), random_dim(), random_dim()};
        return query_row(bank, q.m, q.n, q.k);
    endfunction

    function automatic int pick_entry_count(logic [BANK_W-1:0] bank, int phase);
        int p;
        int cap;
        p = written_prefix(bank);
        if (bank == BANK_SINGLE_TRANSPOSED && phase == FULL_SCAN_PHASE)
            return TABLE_DEPTH;
        if (bank == BANK_SINGLE_TRANSPOSED && phase == OVERSIZE_PHASE)
            return COUNT_MAX;
        cap = (p < 24) ? p : 24;
        case ($urandom_range(0, 7))
            0: return 0;
            1: return (p < 64) ? p : 64;
            default: return $urandom_range(0, cap);
        endcase
    endfunction

    function automatic bit sender_pauses();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < HEAVY_IDLE_PCT;
            IDLE_BOTH:   return $urandom_range(0, 99) < LIGHT_IDLE_PCT;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < HEAVY_IDLE_PCT;
            IDLE_BOTH:     return $urandom_range(0, 99) < LIGHT_IDLE_PCT;
            default:       return 1'b0;
        endcase
    endfunction

    // drive one input word and record what it should cause
    task automatic send_word(input stim_row_t r);
        logic [S_TUSER_W-1:0] user;
        user = '0;
        user[gnl_pkg::TUSER_KIND] = r.op;
        user[gnl_pkg::TUSER_SINGLE] = r.bank[1];
        user[gnl_pkg::TUSER_TRANS] = r.bank[0];
        while (sender_pauses())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{S_PAD_W{1'b0}}, r.flag, r.batch, r.dims.k, r.dims.n, r.dims.m, r.slot};
        s_tuser <= user;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        if (r.op == gnl_pkg::OP_LOAD)
        begin
            shape_store[r.bank][r.slot] = r.dims;
            batch_store[r.bank][r.slot] = r.batch;
            flag_store[r.bank][r.slot] = r.flag;
            written[r.bank][r.slot] = 1'b1;
            loads_sent++;
        end
        else
        begin
            queries_sent++;
            pending_results.push_back(r.typed ? r.typed_result : nearest_choice(r.bank, r.dims));
        end
    endtask

    // valid stays high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [COUNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (index <= REG_ENTRIES_SINGLE_TRANSPOSED)
            entry_limit[index] = value;
    endtask

    task automatic drain_results();
        if (pending_results.size() != 0)
        begin
            s_tvalid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
        end
    endtask

    // wait out all results and any loads still queued behind them
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure_banks(input int phase);
        int b;
        quiesce();
        for (b = 0; b < BANK_COUNT; b++)
            write_reg(CFG_INDEX_W'(REG_ENTRIES_DOUBLE_NORMAL + b),
                      COUNT_W'(pick_entry_count(BANK_W'(b), phase)));
        if ($urandom_range(0, 1))
            write_reg(CFG_INDEX_W'($urandom_range(REG_FIRST_UNUSED, REG_INDEX_MAX)),
                      COUNT_W'($urandom_range(0, COUNT_MAX)));
        cfg_valid <= 1'b0;
    endtask

    task automatic check_result();
        lookup_result_t want;
        if (pending_results.size() == 0)
        begin
            $error("result word with no query waiting: n_batch %h use_flag %b found %b",
                   m_tdata[BATCH_W-1:0], m_tdata[BATCH_W], m_tuser[0]);
            errors++;
        end
        else
        begin
            want = pending_results.pop_front();
            results_checked++;
            if (m_tdata[BATCH_W-1:0] !== want.n_batch)
            begin
                $error("n_batch: expected %h, got %h", want.n_batch, m_tdata[BATCH_W-1:0]);
                errors++;
            end
            if (m_tdata[BATCH_W] !== want.use_flag)
            begin
                $error("use_flag: expected %b, got %b", want.use_flag, m_tdata[BATCH_W]);
                errors++;
            end
            if (m_tuser[0] !== want.found)
            begin
                $error("found: expected %b, got %b", want.found, m_tuser[0]);
                errors++;
            end
        end
    endtask

    // result side: check each accepted word, then decide on a stall
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result();
        m_tready <= !receiver_stalls();
    end

    // watchdog on cycles with no word moving on any port
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int i;
        int phase;
        bit cfg_open;
        stim_row_t row;

        foreach (entry_limit[b])
            entry_limit[b] = '0;

        // directed: empty banks after reset, extreme shapes, ties, ignored registers
        directed_rows.push_back(known_query_row(BANK_DOUBLE_NORMAL, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                                16'hFFFF, 1'b0, 1'b0));
        directed_rows.push_back(known_query_row(BANK_SINGLE_TRANSPOSED, 16'h0000, 16'h1234,
                                                16'h0000, 16'h1234, 1'b0, 1'b0));
        directed_rows.push_back(load_row(BANK_DOUBLE_NORMAL, 8'd0, 16'h0000, 16'h0000, 16'h0000,
                                         16'hFFFF, 1'b1));
        directed_rows.push_back(load_row(BANK_DOUBLE_NORMAL, 8'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                         16'hFFFF, 1'b0));
        directed_rows.push_back(load_row(BANK_DOUBLE_NORMAL, 8'd2, 16'h0010, 16'h0020, 16'h0030,
                                         16'h0020, 1'b1));
        // same shape again later in the bank: the earlier slot must win
        directed_rows.push_back(load_row(BANK_DOUBLE_NORMAL, 8'd3, 16'h0010, 16'h0020, 16'h0030,
                                         16'h0007, 1'b0));
        directed_rows.push_back(load_row(BANK_DOUBLE_NORMAL, 8'd255, 16'h0005, 16'h0005,
                                         16'h0005, 16'h0009, 1'b1));
        directed_rows.push_back(load_row(BANK_DOUBLE_TRANSPOSED, 8'd0, 16'h0001, 16'h0002,
                                         16'h0003, 16'h0002, 1'b1));
        directed_rows.push_back(load_row(BANK_SINGLE_NORMAL, 8'd0, 16'hAAAA, 16'h5555,
                                         16'hAAAA, 16'h5555, 1'b0));
        directed_rows.push_back(load_row(BANK_SINGLE_TRANSPOSED, 8'd0, 16'h0003, 16'h0003,
                                         16'h0003, 16'h0000, 1'b1));
        directed_rows.push_back(reg_row(REG_ENTRIES_DOUBLE_NORMAL, 9'd4));
        directed_rows.push_back(reg_row(REG_ENTRIES_DOUBLE_TRANSPOSED, 9'd1));
        directed_rows.push_back(reg_row(REG_ENTRIES_SINGLE_NORMAL, 9'd1));
        directed_rows.push_back(reg_row(REG_ENTRIES_SINGLE_TRANSPOSED, 9'd1));
        // writes past the last register must not disturb the counts
        directed_rows.push_back(reg_row(REG_INDEX_MAX, 9'h1FF));
        directed_rows.push_back(reg_row(REG_FIRST_UNUSED, 9'd0));
        directed_rows.push_back(known_query_row(BANK_DOUBLE_NORMAL, 16'h0000, 16'h0000, 16'h0000,
                                                16'hFFFF, 1'b1, 1'b1));
        directed_rows.push_back(known_query_row(BANK_DOUBLE_NORMAL, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                                16'hFFFF, 1'b0, 1'b1));
        directed_rows.push_back(query_row(BANK_DOUBLE_NORMAL, 16'h0010, 16'h0020, 16'h0030));
        directed_rows.push_back(query_row(BANK_DOUBLE_NORMAL, 16'h0011, 16'h0020, 16'h0030));
        directed_rows.push_back(query_row(BANK_DOUBLE_NORMAL, 16'h0010, 16'h0021, 16'h0030));
        directed_rows.push_back(query_row(BANK_DOUBLE_NORMAL, 16'h8000, 16'h8000, 16'h8000));
        directed_rows.push_back(query_row(BANK_DOUBLE_TRANSPOSED, 16'h0001, 16'h0002, 16'h0003));
        directed_rows.push_back(query_row(BANK_SINGLE_NORMAL, 16'h0000, 16'h0000, 16'h0000));
        directed_rows.push_back(query_row(BANK_SINGLE_TRANSPOSED, 16'hFFFF, 16'h0000, 16'h0001));

        // reset
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        idle_mode = IDLE_NONE;
        cfg_open = 1'b0;
        for (i = 0; i < directed_rows.size(); i++)
        begin
            row = directed_rows[i];
            if (row.what == ROW_REG)
            begin
                if (!cfg_open)
                    quiesce();
                cfg_open = 1'b1;
                write_reg(row.reg_index, row.reg_value);
            end
            else
            begin
                if (cfg_open)
                    cfg_valid <= 1'b0;
                cfg_open = 1'b0;
                send_word(row);
            end
        end

        // fill the single/transposed bank so that full and oversize scans are legal
        idle_mode = IDLE_BOTH;
        configure_banks(-1);
        while (written_prefix(BANK_SINGLE_TRANSPOSED) < TABLE_DEPTH)
        begin
            if ($urandom_range(0, 3) != 0)
                send_word(random_load(1'b1));
            else
                send_word(random_query());
        end

        // random phases, one idle pattern each
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            idle_mode = idle_mode_t'(phase % 4);
            configure_banks(phase);
            for (i = 0; i < PHASE_WORDS; i++)
            begin
                if ($urandom_range(0, 39) == 0)
                    drain_results();
                if ($urandom_range(0, 9) < 4)
                    send_word(random_load(1'b0));
                else
                    send_word(random_query());
            end
        end

        quiesce();
        $display("run covered %0d words (%0d record loads, %0d queries) over %0d phases",
                 words_sent, loads_sent, queries_sent, PHASE_COUNT + 2);
        $display("%0d results checked; entry counts from empty to full and oversize", 
                 results_checked);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: gemm_tuning_nearest_lookup_unit.f
design/gnl_pkg.sv
design/gnl_front.sv
design/gnl_back.sv
design/gemm_tuning_nearest_lookup_unit.sv
tb/gemm_tuning_nearest_lookup_unit_test.sv
